// ----- hw/rtl/i2csrb_pkg.sv -----
// types and constants shared by the i2c slave register bridge
package i2csrb_pkg;

  typedef enum logic [2:0] {
    OP_ADDR_MATCH = 3'd0,
    OP_RX_BYTE    = 3'd1,
    OP_TX_READY   = 3'd2,
    OP_STOP       = 3'd3,
    OP_NACK       = 3'd4,
    OP_BUS_ERROR  = 3'd5,
    OP_SPURIOUS   = 3'd6
  } opcode_e;

  localparam logic [6:0] OWN_ADDRESS_RESET = 7'h33;
  localparam logic [7:0] DATA_FIRST_POS    = 8'd2;
  localparam logic [7:0] DATA_END_POS      = 8'd6;
  localparam logic [7:0] POS_MAX           = 8'd255;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_OWN_ADDRESS = 1'b0;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  matched_address;
    logic        direction_read;
    logic [7:0]  received_byte;
    logic [31:0] register_read_word;
  } event_t;

  typedef struct packed {
    logic        transmit_valid;
    logic [7:0]  transmit_byte;
    logic        read_strobe;
    logic        write_strobe;
    logic [15:0] register_address;
    logic [31:0] write_word;
    logic [15:0] error_total;
    logic [15:0] transfer_total;
  } result_t;

  typedef struct packed {
    logic advance;
  } stage_ctrl_t;

endpackage

// ----- hw/rtl/i2csrb_if.sv -----
// valid/ready channel interfaces for bus events and results
interface i2csrb_event_if;
  import i2csrb_pkg::*;
  logic   valid;
  logic   ready;
  event_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2csrb_result_if;
  import i2csrb_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/i2csrb_apb_regs.sv -----
// apb configuration register holding the own slave address
module i2csrb_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2csrb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [6:0]                   own_address
);
  import i2csrb_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDRESS_RESET;
    end else if (wr_en && paddr[PADDR_W-1] == REG_OWN_ADDRESS) begin
      own_address <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_OWN_ADDRESS) begin
      prdata = {25'd0, own_address};
    end
  end

endmodule

// ----- hw/rtl/i2csrb_in_stage.sv -----
// input register for incoming bus events
module i2csrb_in_stage (
  input  logic                    clk,
  input  logic                    rst,
  i2csrb_event_if.sink            bus_event,
  input  logic                    advance,
  output i2csrb_pkg::event_t      held,
  output logic                    held_valid
);
  import i2csrb_pkg::*;

  logic take;

  assign bus_event.ready = !held_valid || advance;
  assign take = bus_event.valid && bus_event.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (bus_event.ready) begin
      held_valid <= bus_event.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= bus_event.payload;
    end
  end

endmodule

// ----- hw/rtl/i2csrb_engine.sv -----
// transaction state, event decode and result register
module i2csrb_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [6:0]              own_address,
  input  i2csrb_pkg::event_t      held,
  input  logic                    held_valid,
  output i2csrb_pkg::stage_ctrl_t ctrl,
  i2csrb_result_if.source         result
);
  import i2csrb_pkg::*;

  logic [7:0]  byte_position, byte_position_next;
  logic        write_mode, write_mode_next;
  logic [15:0] address_accumulator, address_accumulator_next;
  logic [31:0] data_accumulator, data_accumulator_next;
  logic [31:0] transmit_word, transmit_word_next;
  logic [15:0] error_counter, error_counter_next;
  logic [15:0] transfer_counter, transfer_counter_next;
  result_t     res_next;
  logic        out_valid;
  logic        fire;
  logic [15:0] addr_base;
  logic [31:0] data_base;
  logic [1:0]  byte_sel;
  logic [7:0]  pos_adv;

  assign ctrl.advance = result.ready || !out_valid;
  assign fire         = held_valid && ctrl.advance;
  assign result.valid = out_valid;

  assign byte_sel = 2'(byte_position - DATA_FIRST_POS);
  assign pos_adv  = (byte_position < POS_MAX) ? byte_position + 8'd1 : byte_position;

  always_comb begin
    byte_position_next       = byte_position;
    write_mode_next          = write_mode;
    address_accumulator_next = address_accumulator;
    data_accumulator_next    = data_accumulator;
    transmit_word_next       = transmit_word;
    error_counter_next       = error_counter;
    transfer_counter_next    = transfer_counter;
    addr_base = (byte_position == 8'd0) ? 16'd0 : address_accumulator;
    data_base = (byte_position == 8'd0) ? 32'd0 : data_accumulator;
    res_next = '0;
    res_next.register_address = address_accumulator;
    res_next.write_word       = data_accumulator;
    case (held.opcode)
      OP_ADDR_MATCH: begin
        if (held.matched_address == own_address) begin
          write_mode_next = !held.direction_read;
        end else begin
          error_counter_next = error_counter + 16'd1;
        end
      end
      OP_RX_BYTE: begin
        address_accumulator_next = addr_base;
        data_accumulator_next    = data_base;
        if (byte_position == 8'd0) begin
          address_accumulator_next = addr_base | {held.received_byte, 8'd0};
        end else if (byte_position < DATA_FIRST_POS) begin
          address_accumulator_next = addr_base | {8'd0, held.received_byte};
        end else if (byte_position < DATA_END_POS) begin
          data_accumulator_next = data_base
                                  | (32'(held.received_byte) << {byte_sel, 3'b000});
        end
        byte_position_next = pos_adv;
      end
      OP_TX_READY: begin
        if (byte_position == DATA_FIRST_POS) begin
          transmit_word_next   = held.register_read_word;
          res_next.read_strobe = 1'b1;
        end
        if (byte_position >= DATA_FIRST_POS && byte_position < DATA_END_POS) begin
          res_next.transmit_byte = transmit_word_next[{byte_sel, 3'b000} +: 8];
        end
        res_next.transmit_valid = 1'b1;
        byte_position_next      = pos_adv;
      end
      OP_STOP: begin
        res_next.write_strobe    = write_mode;
        address_accumulator_next = '0;
        data_accumulator_next    = '0;
        transfer_counter_next    = transfer_counter + 16'd1;
        byte_position_next       = '0;
      end
      OP_NACK: begin
      end
      default: begin
        error_counter_next = error_counter + 16'd1;
      end
    endcase
    res_next.error_total    = error_counter_next;
    res_next.transfer_total = transfer_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      write_mode          <= 1'b0;
      address_accumulator <= '0;
      data_accumulator    <= '0;
      transmit_word       <= '0;
      error_counter       <= '0;
      transfer_counter    <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (ctrl.advance) begin
        out_valid <= held_valid;
      end
      if (fire) begin
        byte_position       <= byte_position_next;
        write_mode          <= write_mode_next;
        address_accumulator <= address_accumulator_next;
        data_accumulator    <= data_accumulator_next;
        transmit_word       <= transmit_word_next;
        error_counter       <= error_counter_next;
        transfer_counter    <= transfer_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.payload <= res_next;
    end
  end

  a_read_is_transmit: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.payload.read_strobe |-> result.payload.transmit_valid)
    else $error("read strobe without transmit");

  a_write_not_transmit: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.payload.write_strobe |-> !result.payload.transmit_valid)
    else $error("write strobe on a transmit result");

  a_stop_clears_position: assert property (@(posedge clk) disable iff (rst)
    fire && held.opcode == OP_STOP |=> byte_position == 8'd0 && address_accumulator == 16'd0)
    else $error("stop left transaction state");

  a_position_monotonic: assert property (@(posedge clk) disable iff (rst)
    fire && held.opcode != OP_STOP |=> byte_position >= $past(byte_position))
    else $error("byte position went back without stop");

  a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(error_counter) && $stable(transfer_counter))
    else $error("counters moved without a transfer");

endmodule

// ----- hw/rtl/i2c_slave_register_bridge.sv -----
// top level of the i2c slave register bridge
// One bus event is taken per clock cycle unless the result side stalls, and gives
// exactly one result. An event passes an input register, is decoded against the
// transaction state and lands in a result register, where the result is held
// until the result side is ready; the state updates as the event enters the
// result register, which lets every event follow the previous one without a gap
// while the result side keeps up.
// The result side stalls the event side only when the result register is full
// and not taken. own_address sits at byte address 0 of the APB port.
module i2c_slave_register_bridge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2csrb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  i2csrb_event_if.sink                   bus_event,
  i2csrb_result_if.source                result
);
  import i2csrb_pkg::*;

  logic [6:0]  own_address;
  event_t      held;
  logic        held_valid;
  stage_ctrl_t ctrl;

  i2csrb_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .own_address (own_address)
  );

  i2csrb_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .bus_event  (bus_event),
    .advance    (ctrl.advance),
    .held       (held),
    .held_valid (held_valid)
  );

  i2csrb_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .own_address (own_address),
    .held        (held),
    .held_valid  (held_valid),
    .ctrl        (ctrl),
    .result      (result)
  );

endmodule

// ----- dv/tb_i2c_slave_register_bridge.sv -----
// self-checking testbench for the i2c slave register bridge
module tb_i2c_slave_register_bridge;
  import i2csrb_pkg::*;

  localparam logic [2:0] OP_UNDEFINED = 3'd7;
  localparam logic [PADDR_W-1:0] OWN_ADDRESS_OFFSET = PADDR_W'(4 * REG_OWN_ADDRESS);
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    event_t  ev;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2csrb_event_if  bus_if ();
  i2csrb_result_if res_if ();

  i2c_slave_register_bridge u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bus_event(bus_if),
    .result   (res_if)
  );

  // bridge state as the checker sees it
  logic [6:0]  slave_address = OWN_ADDRESS_RESET;
  logic [7:0]  byte_pos = '0;
  logic        write_mode = 1'b0;
  logic [15:0] reg_address = '0;
  logic [31:0] data_word = '0;
  logic [31:0] tx_word = '0;
  logic [15:0] error_count = '0;
  logic [15:0] transfer_count = '0;

  result_t     pending_results[$];
  stim_row_t   directed_rows[$];
  bit          failed = 1'b0;
  int          items_sent = 0;
  int          src_burst_left = 0;
  int          idle_cycles = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic event_t bus_ev(logic [2:0] op, logic [6:0] addr, logic dir,
                                    logic [7:0] rx_data, logic [31:0] read_word);
    event_t e;
    e = '{op, addr, dir, rx_data, read_word};
    return e;
  endfunction

  function automatic result_t bus_res(logic tv, logic [7:0] tx_data, logic rd, logic wr,
                                      logic [15:0] addr, logic [31:0] word,
                                      logic [15:0] errs, logic [15:0] xfers);
    result_t r;
    r = '{tv, tx_data, rd, wr, addr, word, errs, xfers};
    return r;
  endfunction

  function automatic event_t random_event(logic [2:0] op);
    return bus_ev(op, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), $urandom());
  endfunction

  function automatic void advance_pos();
    if (byte_pos != POS_MAX) byte_pos++;
  endfunction

  function automatic result_t predict_bus_event(event_t ev);
    result_t r;
    r = '0;
    r.register_address = reg_address;
    r.write_word = data_word;
    case (ev.opcode)
      OP_ADDR_MATCH: begin
        if (ev.matched_address == slave_address) write_mode = ~ev.direction_read;
        else error_count++;
      end
      OP_RX_BYTE: begin
        if (byte_pos == 8'd0) begin
          reg_address = '0;
          data_word = '0;
        end
        if (byte_pos == 8'd0) reg_address[15:8] |= ev.received_byte;
        else if (byte_pos < DATA_FIRST_POS) reg_address[7:0] |= ev.received_byte;
        else if (byte_pos < DATA_END_POS)
          data_word |= 32'(ev.received_byte) << (8 * (byte_pos - DATA_FIRST_POS));
        advance_pos();
      end
      OP_TX_READY: begin
        if (byte_pos == DATA_FIRST_POS) begin
          tx_word = ev.register_read_word;
          r.read_strobe = 1'b1;
        end
        if (byte_pos >= DATA_FIRST_POS && byte_pos < DATA_END_POS)
          r.transmit_byte = 8'(tx_word >> (8 * (byte_pos - DATA_FIRST_POS)));
        r.transmit_valid = 1'b1;
        advance_pos();
      end
      OP_STOP: begin
        r.write_strobe = write_mode;
        reg_address = '0;
        data_word = '0;
        transfer_count++;
        byte_pos = '0;
      end
      OP_NACK: ;
      default: error_count++;
    endcase
    r.error_total = error_count;
    r.transfer_total = transfer_count;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %0h", $time, got);
      failed = 1'b1;
      return;
    end
    want = pending_results.pop_front();
    check_field("transmit_valid", 32'(want.transmit_valid), 32'(got.transmit_valid));
    check_field("transmit_byte", 32'(want.transmit_byte), 32'(got.transmit_byte));
    check_field("read_strobe", 32'(want.read_strobe), 32'(got.read_strobe));
    check_field("write_strobe", 32'(want.write_strobe), 32'(got.write_strobe));
    check_field("register_address", 32'(want.register_address), 32'(got.register_address));
    check_field("write_word", want.write_word, got.write_word);
    check_field("error_total", 32'(want.error_total), 32'(got.error_total));
    check_field("transfer_total", 32'(want.transfer_total), 32'(got.transfer_total));
  endfunction

  // valid stays high into the next transfer when there is no gap
  task automatic send_event(input event_t ev, input bit typed = 1'b0,
                            input result_t want = '0);
    int gap;
    result_t predicted;
    if (src_burst_left > 0) begin
      src_burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0) src_burst_left = $urandom_range(8, 24);
    end
    if (gap > 0) begin
      bus_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bus_if.valid <= 1'b1;
    bus_if.payload <= ev;
    do @(posedge clk); while (!(bus_if.valid && bus_if.ready));
    predicted = predict_bus_event(ev);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic add_row(input event_t ev, input bit typed = 1'b0, input result_t want = '0);
    directed_rows.push_back('{ev, typed, want});
  endtask

  task automatic wait_idle();
    bus_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [6:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= OWN_ADDRESS_OFFSET;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    slave_address = value;
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("own_address", 32'(value), 32'(prdata[6:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_traffic(input int n_items, input bit with_saturation);
    int stop_at;
    int kind;
    int n;
    event_t ev;
    stop_at = items_sent + n_items;
    if (with_saturation) begin
      ev = random_event(OP_ADDR_MATCH);
      ev.matched_address = slave_address;
      ev.direction_read = 1'b0;
      send_event(ev);
      repeat (257) send_event(random_event(OP_RX_BYTE));
      repeat (2) send_event(random_event(OP_TX_READY));
      send_event(random_event(OP_STOP));
    end
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        ev = random_event(OP_ADDR_MATCH);
        if ($urandom_range(0, 9) != 0) ev.matched_address = slave_address;
        ev.direction_read = 1'b0;
        send_event(ev);
        if (kind >= 4) n = 2;
        else if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 9);
        else n = 6;
        repeat (n) send_event(random_event(OP_RX_BYTE));
        if (kind >= 4) begin
          ev = random_event(OP_ADDR_MATCH);
          ev.matched_address = slave_address;
          ev.direction_read = 1'b1;
          send_event(ev);
          repeat ($urandom_range(1, 6)) send_event(random_event(OP_TX_READY));
        end
        send_event(random_event(OP_STOP));
      end else begin
        repeat ($urandom_range(1, 4)) send_event(random_event(3'($urandom_range(0, 7))));
      end
    end
  endtask

  // result side with random stalls and stall-free stretches
  initial begin
    int stall;
    int burst_left;
    burst_left = 0;
    res_if.ready = 1'b0;
    forever begin
      if (burst_left > 0) begin
        burst_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 24);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      check_result(res_if.payload);
    end
  end

  always @(posedge clk) begin
    if ((bus_if.valid && bus_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** i2c_slave_register_bridge: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bus_if.valid = 1'b0;
    bus_if.payload = '0;

    // write transaction with dropped extra byte and transmit past the data
    add_row(bus_ev(OP_NACK, 7'h00, 1'b0, 8'h00, 32'h0), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd0, 16'd0));
    add_row(bus_ev(OP_ADDR_MATCH, 7'h33, 1'b0, 8'h00, 32'h0), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd0, 16'd0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'hFF, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'h00, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'hFF, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'h00, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'h80, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'h01, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'hAA, 32'h0));
    add_row(bus_ev(OP_TX_READY, 7'h00, 1'b0, 8'h00, 32'h5A5A5A5A));
    add_row(bus_ev(OP_STOP, 7'h00, 1'b0, 8'h00, 32'h0), 1'b1,
            bus_res(0, 8'h00, 0, 1, 16'hFF00, 32'h018000FF, 16'd0, 16'd1));
    // register read with repeated start
    add_row(bus_ev(OP_ADDR_MATCH, 7'h33, 1'b0, 8'h00, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'h12, 32'h0));
    add_row(bus_ev(OP_RX_BYTE, 7'h00, 1'b0, 8'h34, 32'h0));
    add_row(bus_ev(OP_ADDR_MATCH, 7'h33, 1'b1, 8'h00, 32'h0));
    add_row(bus_ev(OP_TX_READY, 7'h00, 1'b0, 8'h00, 32'hFFFFFFFF));
    repeat (4) add_row(bus_ev(OP_TX_READY, 7'h00, 1'b0, 8'h00, 32'h0));
    add_row(bus_ev(OP_STOP, 7'h00, 1'b0, 8'h00, 32'h0), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h1234, 32'h0, 16'd0, 16'd2));
    // errors; a wrong address must not set write mode
    add_row(bus_ev(OP_ADDR_MATCH, 7'h00, 1'b0, 8'h00, 32'h0), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd1, 16'd2));
    add_row(bus_ev(OP_BUS_ERROR, 7'h7F, 1'b1, 8'hFF, 32'hFFFFFFFF), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd2, 16'd2));
    add_row(bus_ev(OP_SPURIOUS, 7'h00, 1'b0, 8'h00, 32'h0), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd3, 16'd2));
    add_row(bus_ev(OP_UNDEFINED, 7'h00, 1'b0, 8'h00, 32'h0), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd4, 16'd2));
    add_row(bus_ev(OP_TX_READY, 7'h00, 1'b0, 8'h00, 32'hFFFFFFFF), 1'b1,
            bus_res(1, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd4, 16'd2));
    add_row(bus_ev(OP_STOP, 7'h7F, 1'b1, 8'hFF, 32'hFFFFFFFF), 1'b1,
            bus_res(0, 8'h00, 0, 0, 16'h0000, 32'h0, 16'd4, 16'd3));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    run_traffic(60, 1'b0);
    wait_idle();

    write_own_address(7'h00);
    run_traffic(60, 1'b0);
    wait_idle();

    write_own_address(7'h7F);
    run_traffic(60, 1'b1);
    wait_idle();

    write_own_address(7'($urandom_range(1, 126)));
    run_traffic(60, 1'b0);
    wait_idle();

    write_own_address(7'($urandom_range(0, 127)));
    run_traffic(60, 1'b0);
    wait_idle();

    repeat (8) @(posedge clk);
    if (failed) begin
      $display("** i2c_slave_register_bridge: FAILED **");
    end else begin
      $display("** i2c_slave_register_bridge: PASSED **");
    end
    $finish;
  end

endmodule
